// ===== rtl/core/i2cms_pkg.sv =====
package i2cms_pkg;

  // APB register map: one 32-bit register per word.
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = ApbAddrW - 2;

  localparam logic [RegIdxW-1:0] RegDelayTicks = RegIdxW'(0);

  localparam logic [7:0] DelayTicksReset = 8'd40;

  // Command codes as carried in the mode field.
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_WACK  = 3'd4,
    CMD_READ  = 3'd5,
    CMD_CHECK = 3'd6
  } cmd_e;

  // Bus step sequence. Each command enters at a first step; check shares start's.
  typedef enum logic [4:0] {
    PH_START_IDLE  = 5'd0,
    PH_START_SDA   = 5'd1,
    PH_START_SCL   = 5'd2,
    PH_SEND_DATA   = 5'd3,
    PH_SEND_HIGH   = 5'd4,
    PH_SEND_LOW    = 5'd5,
    PH_WACK_REL    = 5'd6,
    PH_WACK_HIGH   = 5'd7,
    PH_WACK_SAMPLE = 5'd8,
    PH_STOP_PREP   = 5'd9,
    PH_STOP_REL    = 5'd10,
    PH_READ_HIGH   = 5'd11,
    PH_READ_SAMPLE = 5'd12,
    PH_ACK_DRIVE   = 5'd13,
    PH_ACK_HIGH    = 5'd14,
    PH_ACK_LOW     = 5'd15,
    PH_ACK_REL     = 5'd16,
    PH_END         = 5'd17
  } phase_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_level;
    logic       scl_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       ack_missing;
    logic       rejected;
  } out_item_t;

endpackage

// ===== rtl/core/i2cms_if.sv =====
interface i2cms_in_if;
  logic                valid;
  logic                ready;
  i2cms_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cms_out_if;
  logic                 valid;
  logic                 ready;
  i2cms_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/i2c_master_bit_sequencer_unit.sv =====
// I2C master bit sequencer. Each input item is one bus tick: it carries the
// sampled SDA and SCL levels and, while the sequencer is idle, an optional
// command (start, stop, send byte, wait ack, read byte, check device).
// Each input item produces exactly one result item with the open-drain line
// drives, busy and done flags, the last read byte, the ack status and a
// flag for a command that arrived while busy and was dropped.
// Items enter through an input register; the next-state and result logic
// runs from that register straight into the state and the result register.
// A result is offered once its item moves on from the input register; one
// item is taken every cycle as long as the result side keeps up. When the
// receiver stalls, the result register holds its item and the input
// register absorbs one more item before the input ready drops. The
// delay_ticks register (APB, byte address 0) sets the idle ticks after
// each bus step; the user must write it only while no command is in
// progress, as the block does not enforce this. Reset leaves the sequencer
// idle with both lines released, delay_ticks at 40 and both channels empty.
module i2c_master_bit_sequencer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  i2cms_in_if.sink                         in_i,
  i2cms_out_if.source                      out_o,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [i2cms_pkg::ApbAddrW-1:0]   paddr_i,
  input  logic [i2cms_pkg::ApbDataW-1:0]   pwdata_i,
  output logic [i2cms_pkg::ApbDataW-1:0]   prdata_o,
  output logic                             pready_o
);

  // Input stage.
  logic                in_valid_q;
  i2cms_pkg::in_item_t in_item_q;

  // Result stage.
  logic                 out_valid_q;
  i2cms_pkg::out_item_t out_item_q;
  i2cms_pkg::out_item_t out_item_d;

  // Sequencer state.
  logic [7:0]        delay_ticks_q;
  i2cms_pkg::cmd_e   active_q, active_d;
  i2cms_pkg::phase_e phase_q, phase_d;
  logic [2:0]        bit_index_q, bit_index_d;
  logic [7:0]        shift_byte_q, shift_byte_d;
  logic [7:0]        delay_count_q, delay_count_d;
  logic              scl_drive_q, scl_drive_d;
  logic              sda_drive_q, sda_drive_d;
  logic              ack_flag_q, ack_flag_d;
  logic              ack_choice_q, ack_choice_d;
  logic [7:0]        last_read_q, last_read_d;
  logic              done_d;
  logic              rej_d;

  // The buffered item moves on whenever the result register is free or
  // is being emptied in this cycle.
  logic advance;
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  // APB configuration port.
  logic                            reg_wr;
  logic [i2cms_pkg::RegIdxW-1:0]   reg_idx;
  assign reg_idx  = paddr_i[i2cms_pkg::ApbAddrW-1:2];
  assign pready_o = 1'b1;
  assign reg_wr   = psel_i && penable_i && pwrite_i && pready_o &&
                    (reg_idx == i2cms_pkg::RegDelayTicks);
  assign prdata_o = (reg_idx == i2cms_pkg::RegDelayTicks) ?
                    {{(i2cms_pkg::ApbDataW-8){1'b0}}, delay_ticks_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ticks_q <= i2cms_pkg::DelayTicksReset;
    end else if (reg_wr) begin
      delay_ticks_q <= pwdata_i[7:0];
    end
  end

  // Next state: one tick of the sequencer. Command setup comes first; a
  // new command's first bus step runs in the same tick unless check gives up.
  always_comb begin : next_state
    logic run;
    logic finish;
    logic step_end;
    logic sda_in;
    i2cms_pkg::phase_e next_ph;

    active_d      = active_q;
    phase_d       = phase_q;
    bit_index_d   = bit_index_q;
    shift_byte_d  = shift_byte_q;
    delay_count_d = delay_count_q;
    scl_drive_d   = scl_drive_q;
    sda_drive_d   = sda_drive_q;
    ack_flag_d    = ack_flag_q;
    ack_choice_d  = ack_choice_q;
    last_read_d   = last_read_q;
    done_d        = 1'b0;
    rej_d         = 1'b0;
    run           = 1'b0;
    finish        = 1'b0;
    step_end      = 1'b0;
    next_ph       = i2cms_pkg::PH_END;
    sda_in        = in_item_q.sda_level;

    if (active_q != i2cms_pkg::CMD_IDLE) begin
      rej_d = (in_item_q.mode != i2cms_pkg::CMD_IDLE);
      if (delay_count_q != 8'd0) begin
        delay_count_d = delay_count_q - 8'd1;
      end else begin
        run = 1'b1;
      end
    end else if (in_item_q.mode inside {[i2cms_pkg::CMD_START : i2cms_pkg::CMD_CHECK]}) begin
      active_d      = i2cms_pkg::cmd_e'(in_item_q.mode);
      bit_index_d   = 3'd0;
      delay_count_d = 8'd0;
      shift_byte_d  = in_item_q.data_byte;
      ack_choice_d  = in_item_q.send_ack;
      case (i2cms_pkg::cmd_e'(in_item_q.mode))
        i2cms_pkg::CMD_STOP: phase_d = i2cms_pkg::PH_STOP_PREP;
        i2cms_pkg::CMD_SEND: phase_d = i2cms_pkg::PH_SEND_DATA;
        i2cms_pkg::CMD_WACK: phase_d = i2cms_pkg::PH_WACK_REL;
        i2cms_pkg::CMD_READ: begin
          phase_d      = i2cms_pkg::PH_READ_HIGH;
          shift_byte_d = 8'd0;
        end
        default: phase_d = i2cms_pkg::PH_START_IDLE;
      endcase
      // Check device on a bus that is not idle gives up at once.
      if ((in_item_q.mode == i2cms_pkg::CMD_CHECK) &&
          !(in_item_q.sda_level && in_item_q.scl_level)) begin
        ack_flag_d = 1'b1;
        finish     = 1'b1;
      end else begin
        run = 1'b1;
      end
    end

    if (run) begin
      case (phase_d)
        i2cms_pkg::PH_START_IDLE: begin
          sda_drive_d = 1'b1;
          scl_drive_d = 1'b1;
          next_ph     = i2cms_pkg::PH_START_SDA;
        end
        i2cms_pkg::PH_START_SDA: begin
          sda_drive_d = 1'b0;
          next_ph     = i2cms_pkg::PH_START_SCL;
        end
        i2cms_pkg::PH_START_SCL: begin
          scl_drive_d = 1'b0;
          next_ph     = (active_d == i2cms_pkg::CMD_CHECK) ?
                        i2cms_pkg::PH_SEND_DATA : i2cms_pkg::PH_END;
        end
        i2cms_pkg::PH_SEND_DATA: begin
          sda_drive_d = shift_byte_d[3'd7 - bit_index_d];
          next_ph     = i2cms_pkg::PH_SEND_HIGH;
        end
        i2cms_pkg::PH_SEND_HIGH: begin
          scl_drive_d = 1'b1;
          next_ph     = i2cms_pkg::PH_SEND_LOW;
        end
        i2cms_pkg::PH_SEND_LOW: begin
          scl_drive_d = 1'b0;
          if (bit_index_d == 3'd7) begin
            sda_drive_d = 1'b1;
            bit_index_d = 3'd0;
            next_ph     = (active_d == i2cms_pkg::CMD_CHECK) ?
                          i2cms_pkg::PH_WACK_REL : i2cms_pkg::PH_END;
          end else begin
            bit_index_d = bit_index_d + 3'd1;
            next_ph     = i2cms_pkg::PH_SEND_DATA;
          end
        end
        i2cms_pkg::PH_WACK_REL: begin
          sda_drive_d = 1'b1;
          next_ph     = i2cms_pkg::PH_WACK_HIGH;
        end
        i2cms_pkg::PH_WACK_HIGH: begin
          scl_drive_d = 1'b1;
          next_ph     = i2cms_pkg::PH_WACK_SAMPLE;
        end
        i2cms_pkg::PH_WACK_SAMPLE: begin
          ack_flag_d  = sda_in;
          scl_drive_d = 1'b0;
          next_ph     = (active_d == i2cms_pkg::CMD_CHECK) ?
                        i2cms_pkg::PH_STOP_PREP : i2cms_pkg::PH_END;
        end
        i2cms_pkg::PH_STOP_PREP: begin
          sda_drive_d = 1'b0;
          scl_drive_d = 1'b1;
          next_ph     = i2cms_pkg::PH_STOP_REL;
        end
        i2cms_pkg::PH_STOP_REL: begin
          sda_drive_d = 1'b1;
          step_end    = 1'b1;
        end
        i2cms_pkg::PH_READ_HIGH: begin
          sda_drive_d = 1'b1;
          scl_drive_d = 1'b1;
          next_ph     = i2cms_pkg::PH_READ_SAMPLE;
        end
        i2cms_pkg::PH_READ_SAMPLE: begin
          shift_byte_d = {shift_byte_d[6:0], sda_in};
          scl_drive_d  = 1'b0;
          if (bit_index_d == 3'd7) begin
            last_read_d = shift_byte_d;
            bit_index_d = 3'd0;
            next_ph     = i2cms_pkg::PH_ACK_DRIVE;
          end else begin
            bit_index_d = bit_index_d + 3'd1;
            next_ph     = i2cms_pkg::PH_READ_HIGH;
          end
        end
        i2cms_pkg::PH_ACK_DRIVE: begin
          sda_drive_d = !ack_choice_d;
          next_ph     = i2cms_pkg::PH_ACK_HIGH;
        end
        i2cms_pkg::PH_ACK_HIGH: begin
          scl_drive_d = 1'b1;
          next_ph     = i2cms_pkg::PH_ACK_LOW;
        end
        i2cms_pkg::PH_ACK_LOW: begin
          scl_drive_d = 1'b0;
          next_ph     = ack_choice_d ? i2cms_pkg::PH_ACK_REL : i2cms_pkg::PH_END;
        end
        i2cms_pkg::PH_ACK_REL: begin
          sda_drive_d = 1'b1;
          step_end    = 1'b1;
        end
        default: step_end = 1'b1;
      endcase

      if (step_end) begin
        finish = 1'b1;
      end else begin
        delay_count_d = delay_ticks_q;
        phase_d       = next_ph;
      end
    end

    if (finish) begin
      active_d      = i2cms_pkg::CMD_IDLE;
      phase_d       = i2cms_pkg::PH_START_IDLE;
      bit_index_d   = 3'd0;
      delay_count_d = 8'd0;
      done_d        = 1'b1;
    end
  end

  // Result item for this tick.
  always_comb begin
    out_item_d.scl_release = scl_drive_d;
    out_item_d.sda_release = sda_drive_d;
    out_item_d.busy_res    = (active_d != i2cms_pkg::CMD_IDLE);
    out_item_d.done_res    = done_d;
    out_item_d.read_value  = last_read_d;
    out_item_d.ack_missing = ack_flag_d;
    out_item_d.rejected    = rej_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      active_q      <= i2cms_pkg::CMD_IDLE;
      phase_q       <= i2cms_pkg::PH_START_IDLE;
      bit_index_q   <= 3'd0;
      shift_byte_q  <= 8'd0;
      delay_count_q <= 8'd0;
      scl_drive_q   <= 1'b1;
      sda_drive_q   <= 1'b1;
      ack_flag_q    <= 1'b0;
      ack_choice_q  <= 1'b0;
      last_read_q   <= 8'd0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        active_q      <= active_d;
        phase_q       <= phase_d;
        bit_index_q   <= bit_index_d;
        shift_byte_q  <= shift_byte_d;
        delay_count_q <= delay_count_d;
        scl_drive_q   <= scl_drive_d;
        sda_drive_q   <= sda_drive_d;
        ack_flag_q    <= ack_flag_d;
        ack_choice_q  <= ack_choice_d;
        last_read_q   <= last_read_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.data;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

// ===== rtl/core/i2cms_checker.sv =====
module i2cms_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_busy_i,
  input logic out_done_i,
  input logic out_rejected_i
);

  logic out_take;
  logic last_busy_q;

  assign out_take = out_valid_i && out_ready_i;

  // Busy state of the last delivered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_busy_q <= 1'b0;
    end else if (out_take) begin
      last_busy_q <= out_busy_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_done_i |-> !out_busy_i)
    else $error("done reported while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_rejected_i |-> last_busy_q)
    else $error("command rejected while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty result stage");

  // With both stages full, the input may only move when the result does.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && out_valid_i && !out_ready_i |=>
    !in_ready_i || out_ready_i)
    else $error("input stage overrun while output stalled");

endmodule

bind i2c_master_bit_sequencer_unit i2cms_checker u_i2cms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_busy_i     (out_o.data.busy_res),
  .out_done_i     (out_o.data.done_res),
  .out_rejected_i (out_o.data.rejected)
);
